>>> sv/spo2rw_pkg.sv
// ----------------------------------------------------------------------------
// SpO2 ratio window estimator package
// Fixed widths, arithmetic constants, register indexes and the command type
// of the shared divide/square-root unit.
// ----------------------------------------------------------------------------
package spo2rw_pkg;

   localparam int FRAC_BITS     = 16;   // fraction of DC levels and ratios
   localparam int Q_BITS        = 16;   // fraction of retention factors
   localparam int COUNT_BITS    = 10;
   localparam int ENERGY_BITS   = 48;
   localparam int RATIO_BITS    = 18;
   localparam int SPO2_BITS     = 15;
   localparam int PCT_BITS      = 7;
   localparam int FACTOR_BITS   = 16;
   localparam int LEVEL_BITS    = 18;   // dc_minimum, ratio_clamp, min_ratio
   localparam int CSR_DATA_BITS = 18;
   localparam int CSR_INDEX_BITS = 3;
   localparam int DIV_N         = 64;   // dividend width of the shared unit
   localparam int R_BITS        = 35;   // R saturates at 2^34
   localparam int RAW24_BITS    = 31;

   localparam logic [ENERGY_BITS-1:0] ENERGY_MAX   = '1;
   localparam logic [R_BITS-1:0]      R_SAT        = 35'h4_0000_0000;
   localparam logic [12:0]            SLOPE_Q8     = 13'd5965;
   localparam logic [RAW24_BITS-1:0]  OFFSET_Q24   = 31'd1834085253;
   localparam logic [RAW24_BITS-1:0]  FULL_Q24     = 31'd1677721600;
   localparam logic [SPO2_BITS-1:0]   SPO2_FULL_Q8 = 15'd25600;
   localparam logic [SPO2_BITS-1:0]   SPO2_HALF_Q8 = 15'd12800;
   localparam logic [Q_BITS:0]        Q_ONE        = 17'h10000;

   localparam logic [COUNT_BITS-1:0]  COUNT_MAX    = '1;

   // Register reset values.
   localparam logic [COUNT_BITS-1:0]  RST_WINDOW_LENGTH  = 10'd100;
   localparam logic [FACTOR_BITS-1:0] RST_DC_FACTOR      = 16'd62259;
   localparam logic [FACTOR_BITS-1:0] RST_SPO2_SMOOTHING = 16'd52429;
   localparam logic [LEVEL_BITS-1:0]  RST_DC_MINIMUM     = 18'd10;
   localparam logic [LEVEL_BITS-1:0]  RST_RATIO_CLAMP    = 18'd131072;
   localparam logic [LEVEL_BITS-1:0]  RST_MIN_RATIO      = 18'd1311;

   // Register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW_LENGTH  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DC_FACTOR      = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPO2_SMOOTHING = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DC_MINIMUM     = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RATIO_CLAMP    = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_RATIO      = 3'd5;

   typedef struct packed {
      logic start;
      logic sqrt_mode;
   } div_cmd_type;

endpackage

>>> sv/spo2rw_mul.sv
// ----------------------------------------------------------------------------
// SpO2 estimator shared multiplier
// Unsigned product with a registered output, one result per cycle.
// ----------------------------------------------------------------------------
module spo2rw_mul #(
   parameter int A_BITS = 35,
   parameter int B_BITS = 19
) (
   input  logic                     clock,
   input  logic [A_BITS-1:0]        a,
   input  logic [B_BITS-1:0]        b,
   output logic [A_BITS+B_BITS-1:0] p
);

   logic [A_BITS+B_BITS-1:0] p_ff;
   logic [A_BITS+B_BITS-1:0] p_in;

   assign p_in = (A_BITS+B_BITS)'(a) * (A_BITS+B_BITS)'(b);
   assign p    = p_ff;

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

endmodule

>>> sv/spo2rw_divsqrt.sv
// ----------------------------------------------------------------------------
// SpO2 estimator divide and square-root unit
// Restoring division (one quotient bit a cycle) and digit-by-digit integer
// square root (one root bit a cycle) sharing one subtract-and-compare.
// ----------------------------------------------------------------------------
module spo2rw_divsqrt #(
   parameter int N = 64,
   parameter int D = 34
) (
   input  logic                     clock,
   input  logic                     reset,
   input  spo2rw_pkg::div_cmd_type  cmd,
   input  logic [N-1:0]             dividend,
   input  logic [D-1:0]             divisor,
   output logic                     done,
   output logic [N-1:0]             result
);

   localparam int RW = N / 2;
   localparam int WS = (D + 1 > RW + 3) ? D + 1 : RW + 3;
   localparam int CW = $clog2(N + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic          mode_ff, mode_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [N-1:0]  sh_ff, sh_in;
   logic [WS-1:0] rem_ff, rem_in;
   logic [RW-1:0] root_ff, root_in;
   logic [D-1:0]  dsr_ff, dsr_in;

   logic [WS-1:0] a_op, b_op;
   logic [WS:0]   diff;
   logic          ge;

   // The one shared subtract and compare.
   always_comb begin
      if (mode_ff) begin
         a_op = WS'({rem_ff[RW:0], sh_ff[N-1:N-2]});
         b_op = WS'({root_ff, 2'b01});
      end else begin
         a_op = WS'({rem_ff[D-1:0], sh_ff[N-1]});
         b_op = WS'(dsr_ff);
      end
      diff = {1'b0, a_op} - {1'b0, b_op};
      ge   = ~diff[WS];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      mode_in = mode_ff;
      cnt_in  = cnt_ff;
      sh_in   = sh_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      dsr_in  = dsr_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         mode_in = cmd.sqrt_mode;
         cnt_in  = cmd.sqrt_mode ? CW'(RW) : CW'(N);
         sh_in   = dividend;
         rem_in  = '0;
         root_in = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[WS-1:0] : a_op;
         if (mode_ff) begin
            root_in = {root_ff[RW-2:0], ge};
            sh_in   = {sh_ff[N-3:0], 2'b00};
         end else begin
            sh_in = {sh_ff[N-2:0], ge};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      mode_ff <= mode_in;
      sh_ff   <= sh_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      dsr_ff  <= dsr_in;
   end

   assign done   = done_ff;
   assign result = mode_ff ? N'(root_ff) : sh_ff;

endmodule

>>> sv/spo2_ratio_window_estimator_top.sv
// ----------------------------------------------------------------------------
// SpO2 ratio window estimator
// Ratio-of-ratios pulse oximetry over windows of red and infrared samples.
// ----------------------------------------------------------------------------
// Usage: each transfer on the req_ channel carries one red and one infrared
// photodiode sample. The block updates both DC trackers and energy sums,
// and produces no result unless the sample closes a window. At a window end
// the shared divide/square-root unit works out both RMS/DC ratios and R, one
// bit a cycle (two 64-step divisions and a 32-step root per channel, then a
// 64-step division for R). The division for R is skipped when the infrared
// ratio is zero, and the unit is not used at all on a weak signal.
// That unit sets the window-end latency; the per-sample time is set by the
// shared multiplier, used six times per sample. req_stall is high while an
// item is in work. A result sits on the rsp_ channel until its transfer;
// while rsp_stall is high the block holds it and takes no new sample. The
// window sums clear on the result transfer. Reset (synchronous) loads the
// register defaults and clears DC levels, sums, count and the smoothed value.
// Configuration writes through the csr_ port take effect at once; the user
// must make them while idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module spo2_ratio_window_estimator_top #(
   parameter int SAMPLE_BITS = 18
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // Sample channel.
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [SAMPLE_BITS-1:0]                  req_red_sample,
   input  logic [SAMPLE_BITS-1:0]                  req_ir_sample,
   // Result channel.
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [spo2rw_pkg::PCT_BITS-1:0]         rsp_spo2_percent,
   output logic                                    rsp_spo2_valid,
   output logic                                    rsp_signal_ok,
   output logic [spo2rw_pkg::SPO2_BITS-1:0]        rsp_raw_spo2,
   output logic [spo2rw_pkg::SPO2_BITS-1:0]        rsp_smoothed_spo2_out,
   output logic [spo2rw_pkg::RATIO_BITS-1:0]       rsp_red_ac_dc_ratio,
   output logic [spo2rw_pkg::RATIO_BITS-1:0]       rsp_ir_ac_dc_ratio,
   // Configuration port.
   input  logic                                    csr_write_enable,
   input  logic [spo2rw_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [spo2rw_pkg::CSR_DATA_BITS-1:0]    csr_write_data
);

   // DC level width, deviation width and shared multiplier operand widths.
   localparam int DC_W  = SAMPLE_BITS + spo2rw_pkg::FRAC_BITS;
   localparam int DEV_W = SAMPLE_BITS + 1;
   localparam int MA    = (DC_W > spo2rw_pkg::R_BITS) ? DC_W : spo2rw_pkg::R_BITS;
   localparam int MB    = (DEV_W > spo2rw_pkg::Q_BITS + 1) ? DEV_W : spo2rw_pkg::Q_BITS + 1;
   localparam int PW    = MA + MB;
   localparam int AW    = DC_W + spo2rw_pkg::Q_BITS + 2;
   localparam int SQW   = 2 * DEV_W;
   localparam int SUMW  = ((SQW > spo2rw_pkg::ENERGY_BITS) ? SQW : spo2rw_pkg::ENERGY_BITS) + 1;
   localparam int CMPW  = (DC_W > spo2rw_pkg::LEVEL_BITS + spo2rw_pkg::FRAC_BITS) ?
                          DC_W : spo2rw_pkg::LEVEL_BITS + spo2rw_pkg::FRAC_BITS;
   localparam int N     = spo2rw_pkg::DIV_N;

   typedef enum logic [4:0] {
      ST_IDLE, ST_DC0, ST_DC1, ST_DC2, ST_EN0, ST_EN1, ST_EN2, ST_CNT, ST_CHK,
      ST_DIVN, ST_DIVN_W, ST_SQRT, ST_SQRT_W, ST_DIVDC, ST_DIVDC_W,
      ST_DIVR, ST_DIVR_W, ST_MULR, ST_RAW, ST_SM0, ST_SM1, ST_SM2, ST_OUT
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [spo2rw_pkg::COUNT_BITS-1:0]  wlen_ff, wlen_in;
   logic [spo2rw_pkg::FACTOR_BITS-1:0] dcf_ff, dcf_in;
   logic [spo2rw_pkg::FACTOR_BITS-1:0] smf_ff, smf_in;
   logic [spo2rw_pkg::LEVEL_BITS-1:0]  dcmin_ff, dcmin_in;
   logic [spo2rw_pkg::LEVEL_BITS-1:0]  clamp_ff, clamp_in;
   logic [spo2rw_pkg::LEVEL_BITS-1:0]  minr_ff, minr_in;

   // Running state.
   logic [DC_W-1:0]                    dc_red_ff, dc_red_in;
   logic [DC_W-1:0]                    dc_ir_ff, dc_ir_in;
   logic [spo2rw_pkg::ENERGY_BITS-1:0] e_red_ff, e_red_in;
   logic [spo2rw_pkg::ENERGY_BITS-1:0] e_ir_ff, e_ir_in;
   logic [spo2rw_pkg::COUNT_BITS-1:0]  count_ff, count_in;
   logic [spo2rw_pkg::SPO2_BITS-1:0]   smooth_ff, smooth_in;
   logic [spo2rw_pkg::PCT_BITS-1:0]    held_ff, held_in;

   // Working registers.
   logic                               ch_ff, ch_in;
   logic [SAMPLE_BITS-1:0]             xr_ff, xr_in;
   logic [SAMPLE_BITS-1:0]             xi_ff, xi_in;
   logic [AW-1:0]                      acc_ff, acc_in;
   logic [DEV_W-1:0]                   dev_ff, dev_in;
   logic [spo2rw_pkg::RATIO_BITS-1:0]  rr_ff, rr_in;
   logic [spo2rw_pkg::RATIO_BITS-1:0]  ri_ff, ri_in;
   logic [spo2rw_pkg::R_BITS-1:0]      r_ff, r_in;
   logic [spo2rw_pkg::SPO2_BITS-1:0]   raw_ff, raw_in;
   logic                               valid_ff, valid_in;
   logic                               ok_ff, ok_in;

   // Shared units.
   logic [MA-1:0]           mul_a;
   logic [MB-1:0]           mul_b;
   logic [PW-1:0]           mul_p;
   spo2rw_pkg::div_cmd_type div_cmd;
   logic [N-1:0]            div_dividend;
   logic [DC_W-1:0]         div_divisor;
   logic                    div_done;
   logic [N-1:0]            div_res;

   spo2rw_mul #(.A_BITS(MA), .B_BITS(MB)) u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .p     (mul_p)
   );

   spo2rw_divsqrt #(.N(N), .D(DC_W)) u_divsqrt (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .result   (div_res)
   );

   // Helper values for the channel in work.
   logic [SAMPLE_BITS-1:0]             x_sel;
   logic [DC_W-1:0]                    dc_sel;
   logic [spo2rw_pkg::ENERGY_BITS-1:0] e_sel;
   logic [spo2rw_pkg::Q_BITS:0]        one_minus_dcf;
   logic [spo2rw_pkg::Q_BITS:0]        one_minus_smf;
   logic [AW-1:0]                      dc_sum;
   logic [DC_W-1:0]                    xs;
   logic [DC_W-1:0]                    mag;
   logic [DC_W:0]                      mag_rnd;
   logic [SUMW-1:0]                    e_sum;
   logic [spo2rw_pkg::ENERGY_BITS-1:0] e_new;
   logic [spo2rw_pkg::COUNT_BITS-1:0]  count_next;
   logic                               win_end;
   logic                               sig_ok;
   logic [spo2rw_pkg::RATIO_BITS-1:0]  ratio;
   logic [spo2rw_pkg::RAW24_BITS-1:0]  raw24;
   logic [spo2rw_pkg::RAW24_BITS-1:0]  raw_rnd;
   logic [AW-1:0]                      sm_sum;
   logic [AW-1:0]                      sm_full;
   logic [spo2rw_pkg::SPO2_BITS-1:0]   sm;
   logic [spo2rw_pkg::SPO2_BITS-1:0]   sm_rnd;

   always_comb begin
      x_sel  = ch_ff ? xi_ff : xr_ff;
      dc_sel = ch_ff ? dc_ir_ff : dc_red_ff;
      e_sel  = ch_ff ? e_ir_ff : e_red_ff;
      one_minus_dcf = spo2rw_pkg::Q_ONE - {1'b0, dcf_ff};
      one_minus_smf = spo2rw_pkg::Q_ONE - {1'b0, smf_ff};

      // DC tracker: retained part plus new part, rounded back to Q.16.
      dc_sum = acc_ff + (AW'(mul_p) << spo2rw_pkg::Q_BITS)
             + AW'(1 << (spo2rw_pkg::Q_BITS - 1));

      // Deviation of the sample from the updated DC level, in whole units.
      xs      = DC_W'(x_sel) << spo2rw_pkg::FRAC_BITS;
      mag     = (xs >= dc_sel) ? xs - dc_sel : dc_sel - xs;
      mag_rnd = (DC_W+1)'(mag) + (DC_W+1)'(1 << (spo2rw_pkg::FRAC_BITS - 1));

      // Saturating energy accumulation.
      e_sum = SUMW'(e_sel) + SUMW'(mul_p);
      e_new = (e_sum > SUMW'(spo2rw_pkg::ENERGY_MAX)) ? spo2rw_pkg::ENERGY_MAX :
              e_sum[spo2rw_pkg::ENERGY_BITS-1:0];

      // The count stops at full scale, and a full counter also ends a window.
      count_next = (count_ff != spo2rw_pkg::COUNT_MAX) ?
                   count_ff + spo2rw_pkg::COUNT_BITS'(1) : count_ff;
      win_end    = (count_next >= wlen_ff) || (count_next == spo2rw_pkg::COUNT_MAX);

      sig_ok = (CMPW'(dc_red_ff) > (CMPW'(dcmin_ff) << spo2rw_pkg::FRAC_BITS))
            && (CMPW'(dc_ir_ff) > (CMPW'(dcmin_ff) << spo2rw_pkg::FRAC_BITS))
            && (e_ir_ff != '0);

      ratio = (div_res > N'(clamp_ff)) ? clamp_ff : div_res[spo2rw_pkg::RATIO_BITS-1:0];

      // Raw SpO2 in Q.24 is the offset less slope times R, held to 0..100.
      if (PW'(mul_p) >= PW'(spo2rw_pkg::OFFSET_Q24)) begin
         raw24 = '0;
      end else begin
         raw24 = spo2rw_pkg::OFFSET_Q24 - mul_p[spo2rw_pkg::RAW24_BITS-1:0];
      end
      if (raw24 > spo2rw_pkg::FULL_Q24) begin
         raw24 = spo2rw_pkg::FULL_Q24;
      end
      raw_rnd = raw24 + spo2rw_pkg::RAW24_BITS'(32768);

      sm_sum  = acc_ff + AW'(mul_p) + AW'(1 << (spo2rw_pkg::Q_BITS - 1));
      sm_full = sm_sum >> spo2rw_pkg::Q_BITS;
      sm      = (sm_full > AW'(spo2rw_pkg::SPO2_FULL_Q8)) ? spo2rw_pkg::SPO2_FULL_Q8 :
                sm_full[spo2rw_pkg::SPO2_BITS-1:0];
      sm_rnd  = sm + spo2rw_pkg::SPO2_BITS'(128);
   end

   always_comb begin
      state_in  = state_ff;
      wlen_in   = wlen_ff;
      dcf_in    = dcf_ff;
      smf_in    = smf_ff;
      dcmin_in  = dcmin_ff;
      clamp_in  = clamp_ff;
      minr_in   = minr_ff;
      dc_red_in = dc_red_ff;
      dc_ir_in  = dc_ir_ff;
      e_red_in  = e_red_ff;
      e_ir_in   = e_ir_ff;
      count_in  = count_ff;
      smooth_in = smooth_ff;
      held_in   = held_ff;
      ch_in     = ch_ff;
      xr_in     = xr_ff;
      xi_in     = xi_ff;
      acc_in    = acc_ff;
      dev_in    = dev_ff;
      rr_in     = rr_ff;
      ri_in     = ri_ff;
      r_in      = r_ff;
      raw_in    = raw_ff;
      valid_in  = valid_ff;
      ok_in     = ok_ff;

      mul_a        = '0;
      mul_b        = '0;
      div_cmd      = '0;
      div_dividend = '0;
      div_divisor  = '0;

      if (csr_write_enable) begin
         case (csr_index)
            spo2rw_pkg::CSR_WINDOW_LENGTH: begin
               wlen_in = csr_write_data[spo2rw_pkg::COUNT_BITS-1:0];
            end
            spo2rw_pkg::CSR_DC_FACTOR: begin
               dcf_in = csr_write_data[spo2rw_pkg::FACTOR_BITS-1:0];
            end
            spo2rw_pkg::CSR_SPO2_SMOOTHING: begin
               smf_in = csr_write_data[spo2rw_pkg::FACTOR_BITS-1:0];
            end
            spo2rw_pkg::CSR_DC_MINIMUM: begin
               dcmin_in = csr_write_data[spo2rw_pkg::LEVEL_BITS-1:0];
            end
            spo2rw_pkg::CSR_RATIO_CLAMP: begin
               clamp_in = csr_write_data[spo2rw_pkg::LEVEL_BITS-1:0];
            end
            spo2rw_pkg::CSR_MIN_RATIO: begin
               minr_in = csr_write_data[spo2rw_pkg::LEVEL_BITS-1:0];
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               xr_in    = req_red_sample;
               xi_in    = req_ir_sample;
               ch_in    = 1'b0;
               state_in = ST_DC0;
            end
         end
         ST_DC0: begin
            mul_a    = MA'(dc_sel);
            mul_b    = MB'(dcf_ff);
            state_in = ST_DC1;
         end
         ST_DC1: begin
            acc_in   = AW'(mul_p);
            mul_a    = MA'(x_sel);
            mul_b    = MB'(one_minus_dcf);
            state_in = ST_DC2;
         end
         ST_DC2: begin
            if (ch_ff) begin
               dc_ir_in = dc_sum[DC_W+spo2rw_pkg::Q_BITS-1:spo2rw_pkg::Q_BITS];
               ch_in    = 1'b0;
               state_in = ST_EN0;
            end else begin
               dc_red_in = dc_sum[DC_W+spo2rw_pkg::Q_BITS-1:spo2rw_pkg::Q_BITS];
               ch_in     = 1'b1;
               state_in  = ST_DC0;
            end
         end
         ST_EN0: begin
            dev_in   = mag_rnd[DC_W:spo2rw_pkg::FRAC_BITS];
            state_in = ST_EN1;
         end
         ST_EN1: begin
            mul_a    = MA'(dev_ff);
            mul_b    = MB'(dev_ff);
            state_in = ST_EN2;
         end
         ST_EN2: begin
            if (ch_ff) begin
               e_ir_in  = e_new;
               ch_in    = 1'b0;
               state_in = ST_CNT;
            end else begin
               e_red_in = e_new;
               ch_in    = 1'b1;
               state_in = ST_EN0;
            end
         end
         ST_CNT: begin
            count_in = count_next;
            state_in = win_end ? ST_CHK : ST_IDLE;
         end
         ST_CHK: begin
            ok_in    = sig_ok;
            valid_in = 1'b0;
            ch_in    = 1'b0;
            if (sig_ok) begin
               state_in = ST_DIVN;
            end else begin
               // Weak signal: ratios and raw read zero, smoothing holds.
               rr_in    = '0;
               ri_in    = '0;
               raw_in   = '0;
               state_in = ST_OUT;
            end
         end
         ST_DIVN: begin
            // Mean square energy in Q.16.
            div_cmd.start = 1'b1;
            div_dividend  = N'(e_sel) << 16;
            div_divisor   = DC_W'(count_ff);
            state_in      = ST_DIVN_W;
         end
         ST_DIVN_W: begin
            if (div_done) begin
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            // RMS in Q.8.
            div_cmd.start     = 1'b1;
            div_cmd.sqrt_mode = 1'b1;
            div_dividend      = div_res;
            state_in          = ST_SQRT_W;
         end
         ST_SQRT_W: begin
            if (div_done) begin
               state_in = ST_DIVDC;
            end
         end
         ST_DIVDC: begin
            div_cmd.start = 1'b1;
            div_dividend  = N'(div_res[N/2-1:0]) << (spo2rw_pkg::FRAC_BITS + 8);
            div_divisor   = dc_sel;
            state_in      = ST_DIVDC_W;
         end
         ST_DIVDC_W: begin
            if (div_done) begin
               if (!ch_ff) begin
                  rr_in    = ratio;
                  ch_in    = 1'b1;
                  state_in = ST_DIVN;
               end else begin
                  ri_in = ratio;
                  if (ratio == '0) begin
                     // No infrared ratio: R saturates unless red is zero too.
                     r_in     = (rr_ff != '0) ? spo2rw_pkg::R_SAT : '0;
                     state_in = ST_MULR;
                  end else begin
                     state_in = ST_DIVR;
                  end
               end
            end
         end
         ST_DIVR: begin
            div_cmd.start = 1'b1;
            div_dividend  = N'(rr_ff) << 16;
            div_divisor   = DC_W'(ri_ff);
            state_in      = ST_DIVR_W;
         end
         ST_DIVR_W: begin
            if (div_done) begin
               r_in = (div_res > N'(spo2rw_pkg::R_SAT)) ? spo2rw_pkg::R_SAT :
                      div_res[spo2rw_pkg::R_BITS-1:0];
               state_in = ST_MULR;
            end
         end
         ST_MULR: begin
            mul_a    = MA'(r_ff);
            mul_b    = MB'(spo2rw_pkg::SLOPE_Q8);
            state_in = ST_RAW;
         end
         ST_RAW: begin
            raw_in   = raw_rnd[spo2rw_pkg::RAW24_BITS-1:16];
            state_in = ST_SM0;
         end
         ST_SM0: begin
            mul_a    = MA'(smooth_ff);
            mul_b    = MB'(smf_ff);
            state_in = ST_SM1;
         end
         ST_SM1: begin
            acc_in   = AW'(mul_p);
            mul_a    = MA'(raw_ff);
            mul_b    = MB'(one_minus_smf);
            state_in = ST_SM2;
         end
         ST_SM2: begin
            smooth_in = sm;
            if ((sm > spo2rw_pkg::SPO2_HALF_Q8) && (ri_ff > minr_ff) && (rr_ff > minr_ff)) begin
               valid_in = 1'b1;
               held_in  = sm_rnd[spo2rw_pkg::SPO2_BITS-1:8];
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               e_red_in = '0;
               e_ir_in  = '0;
               count_in = '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         wlen_ff   <= spo2rw_pkg::RST_WINDOW_LENGTH;
         dcf_ff    <= spo2rw_pkg::RST_DC_FACTOR;
         smf_ff    <= spo2rw_pkg::RST_SPO2_SMOOTHING;
         dcmin_ff  <= spo2rw_pkg::RST_DC_MINIMUM;
         clamp_ff  <= spo2rw_pkg::RST_RATIO_CLAMP;
         minr_ff   <= spo2rw_pkg::RST_MIN_RATIO;
         dc_red_ff <= '0;
         dc_ir_ff  <= '0;
         e_red_ff  <= '0;
         e_ir_ff   <= '0;
         count_ff  <= '0;
         smooth_ff <= '0;
         held_ff   <= '0;
         ch_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         wlen_ff   <= wlen_in;
         dcf_ff    <= dcf_in;
         smf_ff    <= smf_in;
         dcmin_ff  <= dcmin_in;
         clamp_ff  <= clamp_in;
         minr_ff   <= minr_in;
         dc_red_ff <= dc_red_in;
         dc_ir_ff  <= dc_ir_in;
         e_red_ff  <= e_red_in;
         e_ir_ff   <= e_ir_in;
         count_ff  <= count_in;
         smooth_ff <= smooth_in;
         held_ff   <= held_in;
         ch_ff     <= ch_in;
      end
      xr_ff    <= xr_in;
      xi_ff    <= xi_in;
      acc_ff   <= acc_in;
      dev_ff   <= dev_in;
      rr_ff    <= rr_in;
      ri_ff    <= ri_in;
      r_ff     <= r_in;
      raw_ff   <= raw_in;
      valid_ff <= valid_in;
      ok_ff    <= ok_in;
   end

   // The result registers stay still for the whole output state.
   assign req_stall             = (state_ff != ST_IDLE);
   assign rsp_valid             = (state_ff == ST_OUT);
   assign rsp_spo2_percent      = held_ff;
   assign rsp_spo2_valid        = valid_ff;
   assign rsp_signal_ok         = ok_ff;
   assign rsp_raw_spo2          = raw_ff;
   assign rsp_smoothed_spo2_out = smooth_ff;
   assign rsp_red_ac_dc_ratio   = rr_ff;
   assign rsp_ir_ac_dc_ratio    = ri_ff;

endmodule
